[hdl/lfrs_pkg.sv]
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and constants for the lowest-free-room scheduler: word
// formats, room table sizes, time limits and the controller/datapath link.
// ----------------------------------------------------------------------------
package lfrs_pkg;

  // Room table size and internal time width
  localparam int N_ROOMS   = 16;
  localparam int TIME_BITS = 32;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int ROOM_W  = 7;
  localparam int COUNT_W = 20;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = (N_ROOMS > 1) ? $clog2(N_ROOMS) : 1;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ROOMS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] ROOMS_RESET = CFG_W'(16);

  // Saturation limits
  localparam logic [TIME_W-1:0] TIME_LIMIT =
    (TIME_BITS >= TIME_W) ? {TIME_W{1'b1}} : TIME_W'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Input command codes
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // Job word
  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
  } job_t;

  // Result word
  typedef struct packed {
    logic [ROOM_W-1:0]  room;
    logic               delayed;
    logic [TIME_W-1:0]  actual_start;
    logic [TIME_W-1:0]  actual_end;
    logic [ROOM_W-1:0]  best_room;
    logic [COUNT_W-1:0] best_count;
    logic               overflow;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic sum;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_clear;
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hdl/lowest_free_room_scheduler.sv]
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler
// Places each job in the lowest-numbered free room, or delays it to the room
// that frees up first, and reports the running most-booked room.
// ----------------------------------------------------------------------------
// Each schedule word is taken in the accept step, then the scan reads one room
// of the busy-until table per cycle up to the clamped room count used, then the
// sum step forms the delayed end time and the commit step does the table
// write-back and the result load. A clear word skips the scan but still passes
// through the sum and commit steps.
// The next word is accepted as soon as the previous result has been loaded
// into the output register, even if it is still stalled; its own result then
// waits in the write-back step until the output register is free.
// rooms_in_use is clamped to the room table size, and zero counts as one.
module lowest_free_room_scheduler
  import lfrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // job channel
  input  logic                  job_valid,
  output logic                  job_stall,
  input  job_t                  job,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] rooms_in_use;
  logic [CFG_W-1:0] used;
  logic [IDX_W-1:0] used_m1;
  logic             reg_sel;

  // register decode
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= ROOMS_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REG_ROOMS_IN_USE)) begin
      rooms_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_ROOMS_IN_USE) ?
                  {{(APB_DATA_W-CFG_W){1'b0}}, rooms_in_use} : '0;

  // clamp the room count to the table
  always_comb begin
    if (rooms_in_use > CFG_W'(N_ROOMS)) begin
      used = CFG_W'(N_ROOMS);
    end else if (rooms_in_use == '0) begin
      used = CFG_W'(1);
    end else begin
      used = rooms_in_use;
    end
    used_m1 = IDX_W'(used - CFG_W'(1));
  end

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lfrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfrs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .job          (job),
    .used_m1      (used_m1),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

[hdl/lfrs_ctrl.sv]
// ----------------------------------------------------------------------------
// lfrs_ctrl
// Sequencer: accepts a job word, steps the room scan, then the time sum and
// the table write-back with the result register load.
// ----------------------------------------------------------------------------
module lfrs_ctrl
  import lfrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_SUM    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = !sts.is_clear;
        if (sts.is_clear || sts.scan_last) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // wait here while the previous result is still held
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign job_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/lfrs_dp.sv]
// ----------------------------------------------------------------------------
// lfrs_dp
// Datapath: room table (busy-until, booking count), scan registers, time
// arithmetic, leader tracking and the result register.
// ----------------------------------------------------------------------------
module lfrs_dp
  import lfrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output ctrl_sts_t        sts,
  input  job_t             job,
  input  logic [IDX_W-1:0] used_m1,
  output result_t          result,
  output logic             result_valid,
  input  logic             result_stall
);

  // room table; an entry without its valid bit reads as zero
  logic [N_ROOMS-1:0] room_valid;
  logic [TIME_W-1:0]  busy_until [N_ROOMS];
  logic [COUNT_W-1:0] booking_count [N_ROOMS];

  // latched job
  logic              clear_r;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] dur_r;
  logic              ovf_r;

  // scan state
  logic [IDX_W-1:0]  idx;
  logic              found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  min_idx;
  logic [TIME_W-1:0] min_busy;

  // sum results
  logic [IDX_W-1:0]  pick;
  logic              late;
  logic [TIME_W-1:0] a_start;
  logic [TIME_W-1:0] a_end;

  // leader
  logic [ROOM_W-1:0]  leader_room;
  logic [COUNT_W-1:0] leader_count;

  // input clamp and duration
  logic [TIME_W-1:0] st_c;
  logic [TIME_W-1:0] en_c;
  logic              in_ovf;

  always_comb begin
    st_c   = (job.start_time > TIME_LIMIT) ? TIME_LIMIT : job.start_time;
    en_c   = (job.finish_time > TIME_LIMIT) ? TIME_LIMIT : job.finish_time;
    in_ovf = (job.start_time > TIME_LIMIT) || (job.finish_time > TIME_LIMIT);
  end

  // scan read, one room per cycle
  logic [TIME_W-1:0] scan_busy;
  assign scan_busy = room_valid[idx] ? busy_until[idx] : '0;

  // time sum
  logic [IDX_W-1:0]  sel_idx;
  logic [TIME_W-1:0] sel_start;
  logic [TIME_W-1:0] headroom;
  logic              time_sat;

  always_comb begin
    sel_idx   = found ? free_idx : min_idx;
    sel_start = found ? start_r : min_busy;
    headroom  = TIME_LIMIT - sel_start;
    time_sat  = (dur_r > headroom);
  end

  // count update and leader check
  logic [COUNT_W-1:0] cnt_old;
  logic               cnt_sat;
  logic [COUNT_W-1:0] cnt_new;
  logic [ROOM_W-1:0]  pick_room;
  logic               take_lead;
  logic [ROOM_W-1:0]  leader_room_next;
  logic [COUNT_W-1:0] leader_count_next;

  always_comb begin
    cnt_old   = room_valid[pick] ? booking_count[pick] : '0;
    cnt_sat   = (cnt_old >= COUNT_MAX);
    cnt_new   = cnt_sat ? COUNT_MAX : cnt_old + COUNT_W'(1);
    pick_room = ROOM_W'(pick);
    take_lead = (cnt_new > leader_count) ||
                ((cnt_new == leader_count) && (pick_room < leader_room));
    leader_room_next  = take_lead ? pick_room : leader_room;
    leader_count_next = take_lead ? cnt_new : leader_count;
  end

  // status to controller
  assign sts.is_clear  = clear_r;
  assign sts.scan_last = (idx == used_m1);
  assign sts.out_free  = !result_valid || !result_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      room_valid   <= '0;
      leader_room  <= '0;
      leader_count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (clear_r) begin
          room_valid   <= '0;
          leader_room  <= '0;
          leader_count <= '0;
        end else begin
          room_valid[pick] <= 1'b1;
          leader_room      <= leader_room_next;
          leader_count     <= leader_count_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clear_r <= (job.command == CMD_CLEAR);
      start_r <= st_c;
      dur_r   <= (en_c > st_c) ? en_c - st_c : '0;
      ovf_r   <= in_ovf;
      idx     <= '0;
      found   <= 1'b0;
    end
    if (cmd.scan) begin
      if (!found && (scan_busy <= start_r)) begin
        found    <= 1'b1;
        free_idx <= idx;
      end
      if ((idx == '0) || (scan_busy < min_busy)) begin
        min_busy <= scan_busy;
        min_idx  <= idx;
      end
      idx <= idx + IDX_W'(1);
    end
    if (cmd.sum) begin
      pick    <= sel_idx;
      late    <= !found;
      a_start <= sel_start;
      a_end   <= time_sat ? TIME_LIMIT : sel_start + dur_r;
      if (time_sat) begin
        ovf_r <= 1'b1;
      end
    end
    if (cmd.commit) begin
      if (clear_r) begin
        result <= '0;
      end else begin
        busy_until[pick]    <= a_end;
        booking_count[pick] <= cnt_new;
        result.room         <= pick_room;
        result.delayed      <= late;
        result.actual_start <= a_start;
        result.actual_end   <= a_end;
        result.best_room    <= leader_room_next;
        result.best_count   <= leader_count_next;
        result.overflow     <= ovf_r || cnt_sat;
      end
    end
  end

endmodule
